// ===== rtl/wall_follow_speed_controller_unit_macros.svh =====
// assertion macros for the wall follow speed controller
// expects clk_i and rst_ni in the module that uses them
`ifndef WALL_FOLLOW_SPEED_CONTROLLER_UNIT_MACROS_SVH
`define WALL_FOLLOW_SPEED_CONTROLLER_UNIT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define WFSC_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define WFSC_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wfsc_pkg.sv =====
// shared types and constants for the wall follow speed controller
// no dependencies
package wfsc_pkg;

  localparam int unsigned ECHO_BITS_DEF   = 15;
  localparam int unsigned SPEED_BITS_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned GAIN_BITS = 16;
  localparam int unsigned BASE_BITS = 7;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IDX_BITS  = 3;

  localparam int unsigned TARGET_RST     = 720;
  localparam int unsigned BASE_RST       = 17;
  localparam int unsigned LIMIT_RST      = 30;
  localparam int unsigned GAIN_RST       = 459;
  localparam int unsigned FRONT_OPEN_RST = 8000;
  localparam int unsigned RIGHT_OPEN_RST = 7000;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_TARGET     = 3'd0,
    CFG_BASE       = 3'd1,
    CFG_LIMIT      = 3'd2,
    CFG_GAIN       = 3'd3,
    CFG_FRONT_OPEN = 3'd4,
    CFG_RIGHT_OPEN = 3'd5
  } cfg_idx_e;

  // classification made at the input side for each transaction
  typedef struct packed {
    logic ended;    // run is over, result is zero speeds with finished
    logic near;     // front wall closer than 1.3 x target
    logic backup;   // front wall not farther than 0.7 x target
  } cls_t;

endpackage

// ===== rtl/wfsc_front.sv =====
// input side: run-over tracking, front wall classification, gain x error product
// depends on wfsc_pkg
module wfsc_front
  import wfsc_pkg::*;
#(
  parameter int unsigned ECHO_BITS = ECHO_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [ECHO_BITS-1:0]               right_echo_i,
  input  logic [ECHO_BITS-1:0]               front_echo_i,
  input  logic                               timer_expired_i,
  input  logic                               halt_request_i,
  input  logic [ECHO_BITS-1:0]               target_i,
  input  logic [ECHO_BITS-1:0]               front_open_i,
  input  logic [ECHO_BITS-1:0]               right_open_i,
  input  logic [GAIN_BITS-1:0]               gain_i,
  output cls_t                               cls_o,
  output logic signed [ECHO_BITS+GAIN_BITS:0] corr_o
);

  localparam int unsigned CW = ECHO_BITS + GAIN_BITS + 1;
  localparam int unsigned MW = ECHO_BITS + 4;

  logic                  run_over_q, run_over_d;
  logic                  ended;
  logic [MW-1:0]         front_x10, target_x13, target_x7;
  logic signed [ECHO_BITS:0] err;
  logic signed [CW-1:0]  gain_ext, err_ext;

  assign ended = run_over_q | halt_request_i |
                 (timer_expired_i & ((right_echo_i > right_open_i) |
                                     (front_echo_i > front_open_i)));

  assign run_over_d = run_over_q | (accept_i & ended);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_over_q <= 1'b0;
    end else begin
      run_over_q <= run_over_d;
    end
  end

  assign front_x10  = MW'(front_echo_i) * MW'(10);
  assign target_x13 = MW'(target_i) * MW'(13);
  assign target_x7  = MW'(target_i) * MW'(7);

  assign cls_o.ended  = ended;
  assign cls_o.near   = front_x10 < target_x13;
  assign cls_o.backup = !(front_x10 > target_x7);

  assign err      = $signed({1'b0, target_i}) - $signed({1'b0, right_echo_i});
  assign gain_ext = {{ECHO_BITS{1'b0}}, 1'b0, gain_i};
  assign err_ext  = {{GAIN_BITS{err[ECHO_BITS]}}, err};
  assign corr_o   = gain_ext * err_ext;

endmodule

// ===== rtl/wfsc_fifo.sv =====
// small register queue between the input side and the speed stage
// depends on wfsc_pkg
module wfsc_fifo
  import wfsc_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o  = count_q == NW'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_wr   = wr_i & !full_o;
  assign do_rd   = rd_i & !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + NW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/wfsc_back.sv =====
// speed stage: truncation, front wall override, clamps, imbalance halving,
// output register; depends on wfsc_pkg and the macro header
`include "wall_follow_speed_controller_unit_macros.svh"
module wfsc_back
  import wfsc_pkg::*;
#(
  parameter int unsigned ECHO_BITS  = ECHO_BITS_DEF,
  parameter int unsigned SPEED_BITS = SPEED_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  cls_t                                cls_i,
  input  logic signed [ECHO_BITS+GAIN_BITS:0] corr_i,
  input  logic [BASE_BITS-1:0]                base_i,
  input  logic [BASE_BITS-1:0]                limit_i,
  output logic                                take_o,
  input  logic                                pop_i,
  output logic                                empty_o,
  output logic signed [SPEED_BITS-1:0]        left_speed_o,
  output logic signed [SPEED_BITS-1:0]        right_speed_o,
  output logic                                finished_o
);

  localparam int unsigned CW = ECHO_BITS + GAIN_BITS + 1;
  localparam int unsigned W  = CW + 1;
  localparam int unsigned TW = W - FRAC_BITS;
  localparam int unsigned XW = SPEED_BITS + 9;

  // rounds a Q16 value toward zero
  function automatic logic signed [TW-1:0] trunc0(input logic signed [W-1:0] s);
    logic signed [TW-1:0] q;
    logic                 fix;
    q   = s[W-1:FRAC_BITS];
    fix = s[W-1] & (|s[FRAC_BITS-1:0]);
    return q + TW'(fix);
  endfunction

  function automatic logic signed [8:0] halve0(input logic signed [8:0] v);
    logic signed [8:0] t;
    t = v + 9'(v[8]);
    return t >>> 1;
  endfunction

  function automatic logic [SPEED_BITS-1:0] sat(input logic signed [8:0] v);
    logic signed [XW-1:0] x, mx, mn;
    x  = {{SPEED_BITS{v[8]}}, v};
    mx = {{10{1'b0}}, {(SPEED_BITS-1){1'b1}}};
    mn = {{10{1'b1}}, {(SPEED_BITS-1){1'b0}}};
    if (x > mx) begin
      x = mx;
    end else if (x < mn) begin
      x = mn;
    end
    return x[SPEED_BITS-1:0];
  endfunction

  logic signed [W-1:0]  base_ext, corr_ext, sum_r, sum_l;
  logic signed [TW-1:0] lim_ext, r_raw, l_raw, r_c, l_c;
  logic [8:0]           base_x3;
  logic signed [8:0]    r9, l9, r_h, l_h;
  logic signed [9:0]    diff;
  logic [9:0]           diff_abs;
  logic                 halve;
  logic [SPEED_BITS-1:0] left_d, right_d;

  logic                  out_valid_q, out_valid_d;
  logic [SPEED_BITS-1:0] left_q, right_q;
  logic                  finished_q;

  assign base_ext = {{(W-BASE_BITS-FRAC_BITS){1'b0}}, base_i, {FRAC_BITS{1'b0}}};
  assign corr_ext = {corr_i[CW-1], corr_i};
  assign sum_r    = base_ext + corr_ext;
  assign sum_l    = base_ext - corr_ext;
  assign base_x3  = 9'(base_i) * 9'd3;
  assign lim_ext  = {{(TW-BASE_BITS){1'b0}}, limit_i};

  always_comb begin
    if (cls_i.near) begin
      r_raw = TW'(base_x3 >> 2);
      l_raw = cls_i.backup ? -TW'(8) : TW'(1);
    end else begin
      r_raw = trunc0(sum_r);
      l_raw = trunc0(sum_l);
    end

    if (r_raw > lim_ext) begin
      r_c = lim_ext;
    end else if (r_raw < 0) begin
      r_c = '0;
    end else begin
      r_c = r_raw;
    end

    if (l_raw > lim_ext) begin
      l_c = lim_ext;
    end else if (l_raw < -TW'(7)) begin
      l_c = -TW'(7);
    end else begin
      l_c = l_raw;
    end
  end

  // after clamping both speeds lie in -7..127
  assign r9       = r_c[8:0];
  assign l9       = l_c[8:0];
  assign diff     = 10'(l9) - 10'(r9);
  assign diff_abs = diff[9] ? 10'(-diff) : 10'(diff);
  assign halve    = {diff_abs, 1'b0} > 11'(base_x3);
  assign r_h      = halve ? halve0(r9) : r9;
  assign l_h      = halve ? halve0(l9) : l9;
  assign left_d   = cls_i.ended ? '0 : sat(l_h);
  assign right_d  = cls_i.ended ? '0 : sat(r_h);

  assign take_o      = in_valid_i & (!out_valid_q | pop_i);
  assign out_valid_d = take_o | (out_valid_q & !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      left_q     <= left_d;
      right_q    <= right_d;
      finished_q <= cls_i.ended;
    end
  end

  assign empty_o       = !out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign finished_o    = finished_q;

  `WFSC_IMPLIES(a_finished_zero, out_valid_q && finished_q, left_q == '0 && right_q == '0, "finished result with nonzero speed")
  `WFSC_IMPLIES(a_right_nonneg, out_valid_q && !finished_q, !right_q[SPEED_BITS-1], "negative right speed")
  `WFSC_NEXT(a_take_holds, take_o, out_valid_q, "taken transaction not presented")

endmodule

// ===== rtl/wall_follow_speed_controller_unit.sv =====
// top level of the wall follow speed controller: config registers and the
// front / queue / speed stage chain; depends on wfsc_pkg, wfsc_front, wfsc_fifo, wfsc_back
//
// One result per sensor transaction; one transaction per clock while the queue is not full.
// A pushed transaction is classified and its gain x error product formed in
// the input stage, which writes straight into a QUEUE_DEPTH entry queue; the
// speed stage turns the queue head into a registered result, so a result
// passes through the queue entry and then the output register to the ports.
// The input multiplier and the add / clamp / halve path of the speed stage
// set the clock period.
// Config writes take effect on the next edge and must be done while idle.
// QUEUE_DEPTH must be 2 or more; the block itself does not check it.
module wall_follow_speed_controller_unit
  import wfsc_pkg::*;
#(
  parameter int unsigned ECHO_BITS   = ECHO_BITS_DEF,
  parameter int unsigned SPEED_BITS  = SPEED_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned CFG_W       = (ECHO_BITS > GAIN_BITS) ? ECHO_BITS : GAIN_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [IDX_BITS-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  input  logic                         push,
  output logic                         full,
  input  logic [ECHO_BITS-1:0]         right_echo_i,
  input  logic [ECHO_BITS-1:0]         front_echo_i,
  input  logic                         timer_expired_i,
  input  logic                         halt_request_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [SPEED_BITS-1:0] left_speed_o,
  output logic signed [SPEED_BITS-1:0] right_speed_o,
  output logic                         finished_o
);

  localparam int unsigned CW = ECHO_BITS + GAIN_BITS + 1;
  localparam int unsigned QW = $bits(cls_t) + CW;

  logic [ECHO_BITS-1:0] target_q, front_open_q, right_open_q;
  logic [BASE_BITS-1:0] base_q, limit_q;
  logic [GAIN_BITS-1:0] gain_q;

  logic                 accept;
  cls_t                 front_cls, back_cls;
  logic signed [CW-1:0] front_corr, back_corr;
  logic [QW-1:0]        q_wdata, q_rdata;
  logic                 q_empty, q_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= ECHO_BITS'(TARGET_RST);
      base_q       <= BASE_BITS'(BASE_RST);
      limit_q      <= BASE_BITS'(LIMIT_RST);
      gain_q       <= GAIN_BITS'(GAIN_RST);
      front_open_q <= ECHO_BITS'(FRONT_OPEN_RST);
      right_open_q <= ECHO_BITS'(RIGHT_OPEN_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET:     target_q     <= cfg_wdata_i[ECHO_BITS-1:0];
        CFG_BASE:       base_q       <= cfg_wdata_i[BASE_BITS-1:0];
        CFG_LIMIT:      limit_q      <= cfg_wdata_i[BASE_BITS-1:0];
        CFG_GAIN:       gain_q       <= cfg_wdata_i[GAIN_BITS-1:0];
        CFG_FRONT_OPEN: front_open_q <= cfg_wdata_i[ECHO_BITS-1:0];
        CFG_RIGHT_OPEN: right_open_q <= cfg_wdata_i[ECHO_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push & !full;

  wfsc_front #(
    .ECHO_BITS(ECHO_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .right_echo_i    (right_echo_i),
    .front_echo_i    (front_echo_i),
    .timer_expired_i (timer_expired_i),
    .halt_request_i  (halt_request_i),
    .target_i        (target_q),
    .front_open_i    (front_open_q),
    .right_open_i    (right_open_q),
    .gain_i          (gain_q),
    .cls_o           (front_cls),
    .corr_o          (front_corr)
  );

  assign q_wdata = {front_cls, front_corr};

  wfsc_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (q_empty)
  );

  assign back_cls  = cls_t'(q_rdata[QW-1:CW]);
  assign back_corr = q_rdata[CW-1:0];

  wfsc_back #(
    .ECHO_BITS (ECHO_BITS),
    .SPEED_BITS(SPEED_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (!q_empty),
    .cls_i         (back_cls),
    .corr_i        (back_corr),
    .base_i        (base_q),
    .limit_i       (limit_q),
    .take_o        (q_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .finished_o    (finished_o)
  );

endmodule
